/* rtl/psbw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package psbw_pkg;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEF       = 4096;
    localparam int RAMP_LENGTH_DEF = 20;

    // Fixed field widths.
    localparam int SAMPLE_W = 8;
    localparam int LEVEL_W  = 13;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W = 2;

    // Stream payload widths (fields packed from bit 0, padded to whole bytes).
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 4;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] CAPACITY_RST = 13'd2184;
    localparam logic [LEVEL_W-1:0] WARN_RST     = 13'd546;
    localparam logic [LEVEL_W-1:0] RESUME_RST   = 13'd819;
    localparam logic [LEVEL_W-1:0] PREBUF_RST   = 13'd273;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_WARN     = 2'd1,
        CFG_RESUME   = 2'd2,
        CFG_PREBUF   = 2'd3
    } cfg_idx_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_REJECTED = 3'd1,
        EV_WARNING  = 3'd2,
        EV_READY    = 3'd3,
        EV_STARTED  = 3'd4,
        EV_RAMP     = 3'd5
    } event_t;

    // Where the sample of a result comes from.
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_RAM  = 2'd1,
        SRC_RAMP = 2'd2
    } res_src_t;

    typedef struct packed {
        res_src_t               src;
        event_t                 ev;
        logic [LEVEL_W-1:0]     fill;
    } stage_item_t;

    // Ramp-down table; positions past its end read as zero.
    function automatic logic [SAMPLE_W-1:0] ramp_value(input logic [6:0] k);
        logic [SAMPLE_W-1:0] v;
        case (k)
            7'd0:    v = 8'h7d;
            7'd1:    v = 8'h76;
            7'd2:    v = 8'h6f;
            7'd3:    v = 8'h69;
            7'd4:    v = 8'h62;
            7'd5:    v = 8'h5c;
            7'd6:    v = 8'h55;
            7'd7:    v = 8'h4e;
            7'd8:    v = 8'h48;
            7'd9:    v = 8'h41;
            7'd10:   v = 8'h3b;
            7'd11:   v = 8'h34;
            7'd12:   v = 8'h2e;
            7'd13:   v = 8'h27;
            7'd14:   v = 8'h20;
            7'd15:   v = 8'h1a;
            7'd16:   v = 8'h13;
            7'd17:   v = 8'h0d;
            7'd18:   v = 8'h06;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/pcm_stream_buffer_with_watermarks_top.sv */
// PCM sample ring buffer with free-space watermarks. Push requests write
// 8-bit samples in packets that are admitted or rejected whole on their first
// sample; pull requests return samples in order while playback runs. Each
// transfer on the input gives one result transfer, except a pull that finds
// the ring dry during playback, which gives RAMP_LENGTH ramp-down results.
// The block accepts one transfer per clock cycle while the output is not stalled
// and no ramp is leaving; a result passes through the first-stage register, then
// the output register. The rate is set by the single read-modify-write pass over the
// pointer and level registers, with the sample memory giving registered read data
// in the cycle after the address. During an underrun ramp the input is held off
// while the ramp results leave, since all of them come from one transfer. The
// sample memory needs no clearing pass after reset; it is ready at once.
// Configuration must be written through a plain write port only while the block
// is idle; the block does not enforce this. Writing the capacity empties the ring.
`timescale 1ns / 1ps
`default_nettype none

module pcm_stream_buffer_with_watermarks_top #(
    parameter int DEPTH       = psbw_pkg::DEPTH_DEF,
    parameter int RAMP_LENGTH = psbw_pkg::RAMP_LENGTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port.
    input  wire logic                            cfg_wr_en,
    input  wire logic [psbw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [psbw_pkg::LEVEL_W-1:0]    cfg_wdata,
    // Request channel.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: sample_in[7:0], first_of_packet[8], packet_length[21:9], zero pad.
    input  wire logic [psbw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tlast,   // last_of_packet
    input  wire logic                            s_tuser,   // req_type
    // Result channel.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: sample_out[7:0], fill_level[20:8], zero pad.
    output logic      [psbw_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                                 m_tlast,   // last
    // m_tuser: sample_valid[0], event_code[3:1].
    output logic      [psbw_pkg::M_TUSER_W-1:0]  m_tuser
);
    import psbw_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                acc;
    logic                in_ready;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
    stage_item_t         item;
    logic [SAMPLE_W-1:0] out_sample;
    logic                out_svalid;
    logic [EVENT_W-1:0]  out_event;
    logic [LEVEL_W-1:0]  out_fill;

    // A transfer is taken whenever the first output stage can take its result.
    assign s_tready = in_ready;
    assign acc      = s_tvalid && in_ready;

    psbw_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .acc             (acc),
        .req_type        (s_tuser),
        .sample_in       (s_tdata[7:0]),
        .first_of_packet (s_tdata[8]),
        .last_of_packet  (s_tlast),
        .packet_length   (s_tdata[21:9]),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .item            (item)
    );

    // Sample store. A push and a pull never share a cycle, so a read always
    // sees every earlier write.
    psbw_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    psbw_out #(
        .RAMP_LENGTH (RAMP_LENGTH)
    ) u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (acc),
        .item           (item),
        .ram_rdata      (ram_rdata),
        .in_ready       (in_ready),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_sample       (out_sample),
        .m_sample_valid (out_svalid),
        .m_last         (m_tlast),
        .m_event        (out_event),
        .m_fill         (out_fill)
    );

    assign m_tdata = {{(M_TDATA_W - SAMPLE_W - LEVEL_W){1'b0}}, out_fill, out_sample};
    assign m_tuser = {out_event, out_svalid};

endmodule

`default_nettype wire

/* rtl/psbw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module psbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/psbw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module psbw_ctrl #(
    parameter int DEPTH = psbw_pkg::DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [psbw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [psbw_pkg::LEVEL_W-1:0]     cfg_wdata,
    input  wire logic                             acc,
    input  wire logic                             req_type,
    input  wire logic [psbw_pkg::SAMPLE_W-1:0]    sample_in,
    input  wire logic                             first_of_packet,
    input  wire logic                             last_of_packet,
    input  wire logic [psbw_pkg::LEVEL_W-1:0]     packet_length,
    output logic                                  ram_we,
    output logic      [$clog2(DEPTH)-1:0]         ram_waddr,
    output logic      [psbw_pkg::SAMPLE_W-1:0]    ram_wdata,
    output logic                                  ram_re,
    output logic      [$clog2(DEPTH)-1:0]         ram_raddr,
    output psbw_pkg::stage_item_t                 item
);
    import psbw_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int EW = (CW > LEVEL_W) ? CW : LEVEL_W;

    logic [LEVEL_W-1:0] cap_raw_reg, warn_lvl_reg, resume_lvl_reg, prebuf_lvl_reg;
    logic [AW-1:0]      rd_reg, rd_next, wr_reg, wr_next;
    logic [CW-1:0]      held_reg, held_next, fps_reg, fps_next;
    logic               playing_reg, playing_next, ramp_done_reg, ramp_done_next;
    logic               warn_reg, warn_next, pa_reg, pa_next, pr_reg, pr_next;
    logic [CW-1:0]      cap;
    logic [CW-1:0]      free_now;
    logic [CW-1:0]      free_after;

    function automatic logic [AW-1:0] adv_idx(input logic [AW-1:0] idx,
                                              input logic [CW-1:0] c);
        logic [CW-1:0] n;
        n = CW'(idx) + CW'(1);
        return (n >= c) ? '0 : n[AW-1:0];
    endfunction

    // Effective capacity: zero acts as one, anything above DEPTH as DEPTH.
    always_comb begin
        if (cap_raw_reg == '0) begin
            cap = CW'(1);
        end else if (EW'(cap_raw_reg) > EW'(DEPTH)) begin
            cap = CW'(DEPTH);
        end else begin
            cap = CW'(cap_raw_reg);
        end
    end

    assign free_now = (held_reg < cap) ? cap - held_reg : '0;

    always_comb begin
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        held_next      = held_reg;
        fps_next       = fps_reg;
        playing_next   = playing_reg;
        ramp_done_next = ramp_done_reg;
        warn_next      = warn_reg;
        pa_next        = pa_reg;
        pr_next        = pr_reg;
        free_after     = '0;
        ram_we         = 1'b0;
        ram_waddr      = wr_reg;
        ram_wdata      = sample_in;
        ram_re         = 1'b0;
        ram_raddr      = rd_reg;
        item.src       = SRC_NONE;
        item.ev        = EV_NONE;

        if (acc) begin
            if (req_type == REQ_PUSH) begin
                if (first_of_packet) begin
                    if (!playing_reg && held_reg == '0) begin
                        rd_next = '0;
                        wr_next = '0;
                    end
                    if (EW'(packet_length) <= EW'(free_now)) begin
                        pa_next  = 1'b1;
                        fps_next = free_now;
                        if (!playing_reg) begin
                            pr_next = (EW'(held_reg) >= EW'(prebuf_lvl_reg));
                        end
                    end else begin
                        pa_next = 1'b0;
                        item.ev = EV_REJECTED;
                    end
                end
                if (pa_next) begin
                    // A sample beyond a full ring is dropped without notice.
                    if (held_reg < cap) begin
                        ram_we    = 1'b1;
                        ram_waddr = wr_next;
                        wr_next   = adv_idx(wr_next, cap);
                        held_next = held_reg + CW'(1);
                        if (fps_next != '0) begin
                            fps_next = fps_next - CW'(1);
                        end
                    end
                    if (last_of_packet) begin
                        if (playing_reg) begin
                            if (!warn_reg && EW'(fps_next) <= EW'(warn_lvl_reg)) begin
                                warn_next = 1'b1;
                                item.ev   = EV_WARNING;
                            end
                        end else if (pr_next) begin
                            playing_next   = 1'b1;
                            ramp_done_next = 1'b0;
                            pr_next        = 1'b0;
                            item.ev        = EV_STARTED;
                        end
                        pa_next = 1'b0;
                    end
                end
            end else if (playing_reg) begin
                if (held_reg != '0) begin
                    ram_re     = 1'b1;
                    rd_next    = adv_idx(rd_reg, cap);
                    held_next  = held_reg - CW'(1);
                    free_after = cap - held_next;
                    item.src   = SRC_RAM;
                    if (warn_reg && EW'(free_after) >= EW'(resume_lvl_reg)) begin
                        warn_next = 1'b0;
                        item.ev   = EV_READY;
                    end
                end else begin
                    playing_next = 1'b0;
                    if (!ramp_done_reg) begin
                        ramp_done_next = 1'b1;
                        item.src       = SRC_RAMP;
                        item.ev        = EV_RAMP;
                    end
                end
            end
        end

        // Writing the capacity empties the ring.
        if (cfg_wr_en && cfg_idx_t'(cfg_index) == CFG_CAPACITY) begin
            rd_next   = '0;
            wr_next   = '0;
            held_next = '0;
        end

        item.fill = LEVEL_W'(held_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_raw_reg    <= CAPACITY_RST;
            warn_lvl_reg   <= WARN_RST;
            resume_lvl_reg <= RESUME_RST;
            prebuf_lvl_reg <= PREBUF_RST;
            rd_reg         <= '0;
            wr_reg         <= '0;
            held_reg       <= '0;
            fps_reg        <= '0;
            playing_reg    <= 1'b0;
            ramp_done_reg  <= 1'b0;
            warn_reg       <= 1'b0;
            pa_reg         <= 1'b0;
            pr_reg         <= 1'b0;
        end else begin
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            held_reg      <= held_next;
            fps_reg       <= fps_next;
            playing_reg   <= playing_next;
            ramp_done_reg <= ramp_done_next;
            warn_reg      <= warn_next;
            pa_reg        <= pa_next;
            pr_reg        <= pr_next;
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CAPACITY: cap_raw_reg    <= cfg_wdata;
                    CFG_WARN:     warn_lvl_reg   <= cfg_wdata;
                    CFG_RESUME:   resume_lvl_reg <= cfg_wdata;
                    CFG_PREBUF:   prebuf_lvl_reg <= cfg_wdata;
                    default:      ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/psbw_out.sv */
`timescale 1ns / 1ps
`default_nettype none

module psbw_out #(
    parameter int RAMP_LENGTH = psbw_pkg::RAMP_LENGTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           item_valid,
    input  wire psbw_pkg::stage_item_t          item,
    input  wire logic [psbw_pkg::SAMPLE_W-1:0]  ram_rdata,
    output logic                                in_ready,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [psbw_pkg::SAMPLE_W-1:0]  m_sample,
    output logic                                m_sample_valid,
    output logic                                m_last,
    output logic      [psbw_pkg::EVENT_W-1:0]   m_event,
    output logic      [psbw_pkg::LEVEL_W-1:0]   m_fill
);
    import psbw_pkg::*;

    localparam int RCW = (RAMP_LENGTH > 1) ? $clog2(RAMP_LENGTH) : 1;

    logic              st1_valid_reg;
    stage_item_t       st1_item_reg;
    logic [RCW-1:0]    ramp_cnt_reg;
    logic              out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic              out_svalid_reg, out_last_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [LEVEL_W-1:0] out_fill_reg;
    logic              adv;
    logic              st1_final;
    logic [SAMPLE_W-1:0] st1_sample;

    assign adv       = !out_valid_reg || m_ready;
    assign st1_final = (st1_item_reg.src != SRC_RAMP)
                       || (ramp_cnt_reg == RCW'(RAMP_LENGTH - 1));
    assign in_ready  = !st1_valid_reg || (adv && st1_final);

    always_comb begin
        case (st1_item_reg.src)
            SRC_RAM:  st1_sample = ram_rdata;
            SRC_RAMP: st1_sample = ramp_value(7'(ramp_cnt_reg));
            default:  st1_sample = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ramp_cnt_reg  <= '0;
        end else begin
            if (in_ready) begin
                st1_valid_reg <= item_valid;
            end
            if (adv) begin
                out_valid_reg <= st1_valid_reg;
                if (st1_valid_reg && st1_item_reg.src == SRC_RAMP) begin
                    ramp_cnt_reg <= st1_final ? '0 : ramp_cnt_reg + RCW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            st1_item_reg <= item;
        end
        if (adv) begin
            out_sample_reg <= st1_sample;
            out_svalid_reg <= (st1_item_reg.src != SRC_NONE);
            out_last_reg   <= st1_final;
            out_event_reg  <= st1_item_reg.ev;
            out_fill_reg   <= st1_item_reg.fill;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_sample       = out_sample_reg;
    assign m_sample_valid = out_svalid_reg;
    assign m_last         = out_last_reg;
    assign m_event        = out_event_reg;
    assign m_fill         = out_fill_reg;

endmodule

`default_nettype wire

/* sim/pcm_stream_buffer_with_watermarks_top_tb.sv */
`timescale 1ns / 1ps

// Checks the PCM ring buffer end to end. Requests go in on the slave-side
// stream and every accepted transfer is run through a behavioral copy of the
// buffer kept in this module, which queues the results the block must give.
// A monitor on the master-side stream pops and compares them in order. Both
// sides stall at random except in the last traffic phase.
module pcm_stream_buffer_with_watermarks_top_tb;

    import psbw_pkg::*;

    localparam int RING_DEPTH  = DEPTH_DEF;
    localparam int FADE_LEN    = RAMP_LENGTH_DEF;
    localparam int FADE_TBL_N  = 20;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_PRINTS  = 40;

    // Ramp-down values played once when the ring runs dry during playback.
    localparam logic [SAMPLE_W-1:0] FADE_TABLE [0:FADE_TBL_N-1] = '{
        8'h7d, 8'h76, 8'h6f, 8'h69, 8'h62, 8'h5c, 8'h55, 8'h4e, 8'h48, 8'h41,
        8'h3b, 8'h34, 8'h2e, 8'h27, 8'h20, 8'h1a, 8'h13, 8'h0d, 8'h06, 8'h00
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                vld;
        logic                lst;
        event_t              ev;
        logic [LEVEL_W-1:0]  fill;
    } playback_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEVEL_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [M_TUSER_W-1:0] m_tuser;

    pcm_stream_buffer_with_watermarks_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Scoreboard and run control.
    playback_result_t pending_results[$];
    int  mismatches    = 0;
    int  requests_sent = 0;
    int  stall_left    = 0;
    int  idle_cycles   = 0;
    logic quiet        = 1'b0;

    // Behavioral copy of the buffer: registers, ring and control flags.
    logic [LEVEL_W-1:0]  cap_reg, warn_reg, resume_reg, prebuf_reg;
    logic [SAMPLE_W-1:0] ring_mem [0:RING_DEPTH-1];
    int   rd_ptr, wr_ptr, held, pkt_free;
    logic is_playing, ramp_spent, warn_up, pkt_open, prefill_ok;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // A capacity of zero behaves as one entry, anything past the memory as
    // the full memory.
    function automatic int ring_size();
        int c;
        c = int'(cap_reg);
        if (c == 0) c = 1;
        if (c > RING_DEPTH) c = RING_DEPTH;
        return c;
    endfunction

    function automatic int next_ptr(input int p);
        return (p + 1 >= ring_size()) ? 0 : p + 1;
    endfunction

    function automatic int free_entries();
        int c;
        c = ring_size();
        return (held < c) ? c - held : 0;
    endfunction

    function automatic void queue_result(input logic [SAMPLE_W-1:0] s, input logic v,
                                         input logic l, input event_t e);
        playback_result_t r;
        r.smp  = s;
        r.vld  = v;
        r.lst  = l;
        r.ev   = e;
        r.fill = held[LEVEL_W-1:0];
        pending_results.push_back(r);
    endfunction

    task automatic reset_buffer_state();
        cap_reg    = CAPACITY_RST;
        warn_reg   = WARN_RST;
        resume_reg = RESUME_RST;
        prebuf_reg = PREBUF_RST;
        foreach (ring_mem[i]) ring_mem[i] = '0;
        rd_ptr     = 0;
        wr_ptr     = 0;
        held       = 0;
        pkt_free   = 0;
        is_playing = 1'b0;
        ramp_spent = 1'b0;
        warn_up    = 1'b0;
        pkt_open   = 1'b0;
        prefill_ok = 1'b0;
    endtask

    task automatic apply_register(input cfg_idx_t idx, input logic [LEVEL_W-1:0] val);
        case (idx)
            CFG_CAPACITY: begin
                // Writing the capacity empties the ring.
                cap_reg = val;
                rd_ptr  = 0;
                wr_ptr  = 0;
                held    = 0;
            end
            CFG_WARN:   warn_reg   = val;
            CFG_RESUME: resume_reg = val;
            CFG_PREBUF: prebuf_reg = val;
            default: ;
        endcase
    endtask

    // Works out the results of one accepted request and queues them.
    task automatic predict_buffer_step(input logic req, input logic [SAMPLE_W-1:0] smp,
                                       input logic first, input logic lastp,
                                       input logic [LEVEL_W-1:0] plen);
        event_t ev;
        int     fr;
        logic [SAMPLE_W-1:0] v;
        ev = EV_NONE;
        if (req == REQ_PUSH) begin
            if (first) begin
                // An idle, empty ring starts over at entry zero.
                if (!is_playing && held == 0) begin
                    rd_ptr = 0;
                    wr_ptr = 0;
                end
                fr = free_entries();
                if (int'(plen) <= fr) begin
                    pkt_open = 1'b1;
                    pkt_free = fr;
                    if (!is_playing) prefill_ok = (held >= int'(prebuf_reg));
                end else begin
                    pkt_open = 1'b0;
                    ev = EV_REJECTED;
                end
            end
            if (pkt_open) begin
                // A sample that finds the ring full is dropped without notice.
                if (held < ring_size()) begin
                    ring_mem[wr_ptr] = smp;
                    wr_ptr = next_ptr(wr_ptr);
                    held++;
                    if (pkt_free > 0) pkt_free--;
                end
                if (lastp) begin
                    if (is_playing) begin
                        if (!warn_up && pkt_free <= int'(warn_reg)) begin
                            warn_up = 1'b1;
                            ev = EV_WARNING;
                        end
                    end else if (prefill_ok) begin
                        is_playing = 1'b1;
                        ramp_spent = 1'b0;
                        prefill_ok = 1'b0;
                        ev = EV_STARTED;
                    end
                    pkt_open = 1'b0;
                end
            end
            queue_result('0, 1'b0, 1'b1, ev);
        end else if (!is_playing) begin
            queue_result('0, 1'b0, 1'b1, EV_NONE);
        end else if (held > 0) begin
            v = ring_mem[rd_ptr];
            rd_ptr = next_ptr(rd_ptr);
            held--;
            if (warn_up && free_entries() >= int'(resume_reg)) begin
                warn_up = 1'b0;
                ev = EV_READY;
            end
            queue_result(v, 1'b1, 1'b1, ev);
        end else begin
            // Dry ring: one ramp-down run, then playback stops.
            is_playing = 1'b0;
            if (!ramp_spent) begin
                ramp_spent = 1'b1;
                for (int k = 0; k < FADE_LEN; k++)
                    queue_result((k < FADE_TBL_N) ? FADE_TABLE[k] : '0, 1'b1,
                                 (k == FADE_LEN - 1), EV_RAMP);
            end else begin
                queue_result('0, 1'b0, 1'b1, EV_NONE);
            end
        end
    endtask

    // Sends one request. The valid stays high after the transfer; the next
    // call either replaces the data or opens a gap at the next falling edge.
    task automatic send_request(input logic req, input logic [SAMPLE_W-1:0] smp,
                                input logic first, input logic lastp,
                                input logic [LEVEL_W-1:0] plen);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, plen, first, smp};
        s_tlast  <= lastp;
        s_tuser  <= req;
        do @(posedge aclk); while (!s_tready);
        predict_buffer_step(req, smp, first, lastp, plen);
        requests_sent++;
    endtask

    // Drops the valid and waits until every expected result is back, plus a
    // margin for the result pipeline.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [LEVEL_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_register(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(input logic [LEVEL_W-1:0] cap, input logic [LEVEL_W-1:0] warn,
                                  input logic [LEVEL_W-1:0] resume,
                                  input logic [LEVEL_W-1:0] prebuf);
        wait_for_drain();
        write_register(CFG_CAPACITY, cap);
        write_register(CFG_WARN, warn);
        write_register(CFG_RESUME, resume);
        write_register(CFG_PREBUF, prebuf);
    endtask

    // Sends one packet of random samples. Most packets are well formed; some
    // declare a wrong length, run past their length, or lose a marker.
    task automatic send_packet(input int max_len);
        int len, total, declared;
        int flaw;
        logic has_first, has_last;
        len       = $urandom_range(1, max_len);
        total     = len;
        declared  = len;
        has_first = 1'b1;
        has_last  = 1'b1;
        flaw      = $urandom_range(0, 19);
        case (flaw)
            0, 1: declared = $urandom_range(0, 8191);
            2, 3: total = len + $urandom_range(1, 4);
            4:    has_last = 1'b0;
            5:    has_first = 1'b0;
            default: ;
        endcase
        for (int k = 0; k < total; k++)
            send_request(REQ_PUSH, SAMPLE_W'($urandom_range(0, 255)), has_first && (k == 0),
                         has_last && (k == total - 1),
                         (k == 0) ? LEVEL_W'(declared) : LEVEL_W'($urandom_range(0, 8191)));
    endtask

    task automatic test_idle_and_reject();
        // Default registers: a pull while idle, pushes outside a packet, a
        // packet too big for the ring, and a zero-length packet.
        send_request(REQ_PULL, 8'h00, 1'b0, 1'b0, 13'd0);
        send_request(REQ_PUSH, 8'hff, 1'b0, 1'b0, 13'd5);
        send_request(REQ_PUSH, 8'h00, 1'b1, 1'b0, 13'd8191);
        send_request(REQ_PUSH, 8'h55, 1'b0, 1'b1, 13'd0);
        send_request(REQ_PUSH, 8'haa, 1'b1, 1'b1, 13'd0);
    endtask

    task automatic test_small_ring();
        apply_settings(13'd6, 13'd2, 13'd4, 13'd2);
        // The first packet prefills; the second finds enough held and starts.
        send_request(REQ_PUSH, 8'h00, 1'b1, 1'b0, 13'd2);
        send_request(REQ_PUSH, 8'hff, 1'b0, 1'b1, 13'd0);
        send_request(REQ_PUSH, 8'h12, 1'b1, 1'b0, 13'd2);
        send_request(REQ_PUSH, 8'h34, 1'b0, 1'b1, 13'd2);
        // One-sample packet leaves little room: the warning goes up.
        send_request(REQ_PUSH, 8'h5a, 1'b1, 1'b1, 13'd1);
        // Runs past its declared length into a full ring.
        send_request(REQ_PUSH, 8'ha5, 1'b1, 1'b0, 13'd1);
        send_request(REQ_PUSH, 8'h0f, 1'b0, 1'b0, 13'd1);
        send_request(REQ_PUSH, 8'hf0, 1'b0, 1'b1, 13'd1);
        // No room at all: rejected, the rest is dropped.
        send_request(REQ_PUSH, 8'h77, 1'b1, 1'b0, 13'd2);
        send_request(REQ_PUSH, 8'h88, 1'b0, 1'b1, 13'd2);
        // Drain the ring (ready comes on the way), underrun ramp, idle pull.
        repeat (8) send_request(REQ_PULL, 8'hff, 1'b1, 1'b1, 13'd8191);
    endtask

    task automatic test_random_traffic(input logic [LEVEL_W-1:0] cap,
                                       input logic [LEVEL_W-1:0] warn,
                                       input logic [LEVEL_W-1:0] resume,
                                       input logic [LEVEL_W-1:0] prebuf, input int count);
        int stop_at, pick, max_len;
        apply_settings(cap, warn, resume, prebuf);
        stop_at = requests_sent + count;
        max_len = (ring_size() < 12) ? ring_size() : 12;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_packet(max_len);
            else if (pick < 90)
                repeat ($urandom_range(1, 8))
                    send_request(REQ_PULL, SAMPLE_W'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 LEVEL_W'($urandom_range(0, 8191)));
            else
                send_request(REQ_PUSH, SAMPLE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             LEVEL_W'($urandom_range(0, 8191)));
        end
    endtask

    // Result sink: ready drops in random bursts.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compares every result transfer with the oldest expectation.
    always @(posedge aclk) begin : check_results
        playback_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result smp=%02h ev=%0d fill=%0d",
                                          m_tdata[7:0], m_tuser[3:1], m_tdata[20:8]));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] != want.smp || m_tuser[0] != want.vld ||
                    m_tlast != want.lst || m_tuser[3:1] != want.ev ||
                    m_tdata[20:8] != want.fill)
                    report_mismatch($sformatf(
                        "got smp=%02h vld=%0d last=%0d ev=%0d fill=%0d, want %02h %0d %0d %0d %0d",
                        m_tdata[7:0], m_tuser[0], m_tlast, m_tuser[3:1], m_tdata[20:8],
                        want.smp, want.vld, want.lst, want.ev, want.fill));
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        reset_buffer_state();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_and_reject();
        test_small_ring();
        test_random_traffic(13'd16, 13'd5, 13'd9, 13'd6, 90);
        test_random_traffic(13'd0, 13'd0, 13'd0, 13'd0, 50);
        test_random_traffic(13'd8191, 13'd4095, 13'd4096, 13'd12, 80);
        test_random_traffic(13'd4096, 13'd8191, 13'd8191, 13'd8191, 30);
        test_random_traffic(13'd33, 13'd10, 13'd20, 13'd0, 60);
        quiet = 1'b1;
        test_random_traffic(13'd24, 13'd6, 13'd12, 13'd8, 90);

        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
rtl/psbw_pkg.sv
rtl/psbw_ram.sv
rtl/psbw_ctrl.sv
rtl/psbw_out.sv
rtl/pcm_stream_buffer_with_watermarks_top.sv
sim/pcm_stream_buffer_with_watermarks_top_tb.sv
